>>> hw/rtl/cbm_pkg.sv
package cbm_pkg;

  localparam int RAM_BYTES        = 32768;
  localparam int RAM_AW           = $clog2(RAM_BYTES);
  localparam int ROM_ADDRESS_BITS = 21;
  localparam int ROM_ADDR_W       = 21;
  localparam int BOOT_BYTES       = 256;
  localparam int BANK_SHIFT       = 14;
  localparam int CFG_AW           = 4;
  localparam int CFG_DW           = 32;

  localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
  localparam logic [3:0]  RAM_KEY       = 4'hA;

  typedef enum logic [2:0] {
    REGION_CART_ROM = 3'd0,
    REGION_BOOT_ROM = 3'd1,
    REGION_RAM      = 3'd2,
    REGION_OPEN_BUS = 3'd3,
    REGION_NONE     = 3'd4
  } region_t;

  typedef enum logic [1:0] {
    CFG_ROM_BANKS = 2'd0,
    CFG_RAM_BANKS = 2'd1,
    CFG_BOOT_ROM  = 2'd2,
    CFG_RAM_EN    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    region_t                 region;
    logic [ROM_ADDR_W-1:0]   rom_addr;
    logic                    ram_rd;
    logic                    ram_we;
    logic [RAM_AW-1:0]       ram_addr;
  } dec_t;

  // The bank count rounds down to a power of two; a count of zero acts as one.
  function automatic logic [ROM_ADDR_W-1:0] rom_mask_f(input logic [7:0] count);
    logic [3:0]            msb;
    logic [ROM_ADDR_W-1:0] m;
    msb = '0;
    for (int i = 0; i < 8; i++) begin
      if (count[i]) msb = 4'(i);
    end
    for (int b = 0; b < ROM_ADDR_W; b++) begin
      m[b] = (b < int'(msb) + BANK_SHIFT) && (b < ROM_ADDRESS_BITS);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/cartridge_bank_mapper_core.sv
// An accepted transfer is held in the pipeline stage and moves to the output registers when out_stall is low.
// Throughput: one transfer per cycle while out_stall is low; the external RAM has one read and one write port.
// A RAM write commits at the acceptance edge, so a following read sees it.
// Reset (synchronous, rst_n low) restores the register defaults and empties the pipeline.
// External RAM contents are not cleared by reset.
module cartridge_bank_mapper_core import cbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [15:0]           in_bus_address,
  input  logic [7:0]            in_write_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_region,
  output logic [ROM_ADDR_W-1:0] out_rom_address,
  output logic [7:0]            out_read_data
);

  dec_t                  dec;
  dec_t                  pipe_dec_r;
  logic                  pipe_valid_r;
  logic                  pipe_adv;
  logic                  accept;
  logic                  ram_re;
  logic                  ram_we;
  logic [7:0]            ram_q;
  logic                  out_valid_r;
  region_t               out_region_r;
  logic [ROM_ADDR_W-1:0] out_rom_r;
  logic [7:0]            out_data_r;
  logic [7:0]            data_nxt;

  assign pready   = 1'b1;
  assign pipe_adv = !out_valid_r || !out_stall;
  assign in_stall = pipe_valid_r && !pipe_adv;
  assign accept   = in_valid && !in_stall;
  assign ram_re   = accept && dec.ram_rd;
  assign ram_we   = accept && dec.ram_we;

  cbm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .accept         (accept),
    .in_kind        (in_kind),
    .in_bus_address (in_bus_address),
    .in_write_value (in_write_value),
    .dec            (dec)
  );

  cbm_ram #(
    .AW (RAM_AW),
    .DW (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dec.ram_addr),
    .wdata (in_write_value),
    .re    (ram_re),
    .raddr (dec.ram_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
    end else if (!in_stall) begin
      pipe_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pipe_dec_r <= dec;
    end
  end

  always_comb begin
    case (pipe_dec_r.region)
      REGION_RAM:      data_nxt = ram_q;
      REGION_OPEN_BUS: data_nxt = 8'hFF;
      default:         data_nxt = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_adv) begin
      out_valid_r <= pipe_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv && pipe_valid_r) begin
      out_region_r <= pipe_dec_r.region;
      out_rom_r    <= pipe_dec_r.rom_addr;
      out_data_r   <= data_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_region      = out_region_r;
  assign out_rom_address = out_rom_r;
  assign out_read_data   = out_data_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pipe_valid_r)
    else $error("Input stalled with an empty pipeline stage.");

  a_ram_read_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re || ram_we) |-> (in_valid && !in_stall))
    else $error("RAM accessed without an accepted transfer.");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("Pipeline item did not reach the output register.");

  a_open_bus_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_region_r == REGION_OPEN_BUS)) |-> (out_data_r == 8'hFF))
    else $error("Open bus result without 0xFF data.");
`endif

endmodule

>>> hw/rtl/cbm_ram.sv
module cbm_ram #(
  parameter int AW = 15,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cbm_ctrl.sv
module cbm_ctrl import cbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  input  logic              accept,
  input  logic              in_kind,
  input  logic [15:0]       in_bus_address,
  input  logic [7:0]        in_write_value,
  output dec_t              dec
);

  logic [7:0] rom_bank_count_r;
  logic [2:0] ram_page_count_r;
  logic       boot_present_r;
  logic       ram_master_en_r;
  logic [4:0] low_bank_r, low_bank_nxt;
  logic [1:0] upper_bank_r, upper_bank_nxt;
  logic       mode_r, mode_nxt;
  logic       ram_unlocked_r, ram_unlocked_nxt;
  logic       boot_active_r, boot_active_nxt;

  cfg_idx_t              cfg_idx;
  logic                  cfg_we;
  logic                  ram_usable;
  logic                  in_ram_window;
  logic [1:0]            ram_page_mask;
  logic [1:0]            ram_page;
  logic [14:0]           ram_full;
  logic [ROM_ADDR_W-1:0] rom_mask;
  logic [6:0]            rom_bank;

  assign cfg_idx = cfg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_count_r <= 8'd2;
      ram_page_count_r <= 3'd0;
      boot_present_r   <= 1'b0;
      ram_master_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROM_BANKS: rom_bank_count_r <= pwdata[7:0];
        CFG_RAM_BANKS: ram_page_count_r <= pwdata[2:0];
        CFG_BOOT_ROM:  boot_present_r   <= pwdata[0];
        CFG_RAM_EN:    ram_master_en_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_ROM_BANKS: prdata = CFG_DW'(rom_bank_count_r);
      CFG_RAM_BANKS: prdata = CFG_DW'(ram_page_count_r);
      CFG_BOOT_ROM:  prdata = CFG_DW'(boot_present_r);
      CFG_RAM_EN:    prdata = CFG_DW'(ram_master_en_r);
      default:       prdata = '0;
    endcase
  end

  assign ram_usable    = ram_unlocked_r && ram_master_en_r && (ram_page_count_r != 3'd0);
  assign in_ram_window = (in_bus_address[15:13] == 3'b101);
  assign ram_page_mask = (ram_page_count_r >= 3'd4) ? 2'b11 :
                         (ram_page_count_r >= 3'd2) ? 2'b01 : 2'b00;
  assign ram_page      = mode_r ? (upper_bank_r & ram_page_mask) : 2'b00;
  assign ram_full      = {ram_page, in_bus_address[12:0]};
  assign rom_mask      = rom_mask_f(rom_bank_count_r);
  assign rom_bank      = {upper_bank_r, low_bank_r};

  always_comb begin
    dec          = '0;
    dec.region   = REGION_NONE;
    dec.ram_addr = ram_full[RAM_AW-1:0];
    if (in_kind) begin
      dec.ram_we = in_ram_window && ram_usable;
    end else if (in_bus_address[15:14] == 2'b00) begin
      if (boot_active_r && (in_bus_address < 16'(BOOT_BYTES))) begin
        dec.region   = REGION_BOOT_ROM;
        dec.rom_addr = ROM_ADDR_W'(in_bus_address);
      end else begin
        dec.region = REGION_CART_ROM;
        if (mode_r) begin
          dec.rom_addr = {upper_bank_r, 5'd0, in_bus_address[13:0]} & rom_mask;
        end else begin
          dec.rom_addr = ROM_ADDR_W'(in_bus_address[13:0]) & rom_mask;
        end
      end
    end else if (in_bus_address[15:14] == 2'b01) begin
      dec.region   = REGION_CART_ROM;
      dec.rom_addr = {rom_bank, in_bus_address[13:0]} & rom_mask;
    end else if (in_ram_window && ram_usable) begin
      dec.region = REGION_RAM;
      dec.ram_rd = 1'b1;
    end else begin
      dec.region = REGION_OPEN_BUS;
    end
  end

  always_comb begin
    low_bank_nxt     = low_bank_r;
    upper_bank_nxt   = upper_bank_r;
    mode_nxt         = mode_r;
    ram_unlocked_nxt = ram_unlocked_r;
    boot_active_nxt  = boot_active_r;
    if (cfg_we && (cfg_idx == CFG_BOOT_ROM)) begin
      boot_active_nxt = pwdata[0];
    end
    if (accept && in_kind) begin
      if (in_bus_address == BOOT_OFF_ADDR) begin
        if (in_write_value == 8'd1) boot_active_nxt = 1'b0;
      end else begin
        unique case (in_bus_address[15:13])
          3'b000: ram_unlocked_nxt = (in_write_value[3:0] == RAM_KEY);
          3'b001: low_bank_nxt = (in_write_value[4:0] == 5'd0) ? 5'd1 : in_write_value[4:0];
          3'b010: upper_bank_nxt = in_write_value[1:0];
          3'b011: mode_nxt = in_write_value[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bank_r     <= 5'd1;
      upper_bank_r   <= 2'd0;
      mode_r         <= 1'b0;
      ram_unlocked_r <= 1'b0;
      boot_active_r  <= 1'b0;
    end else begin
      low_bank_r     <= low_bank_nxt;
      upper_bank_r   <= upper_bank_nxt;
      mode_r         <= mode_nxt;
      ram_unlocked_r <= ram_unlocked_nxt;
      boot_active_r  <= boot_active_nxt;
    end
  end

endmodule
